>>> rtl/isort_pkg.sv
// Shared constants and types of the insertion-cell sorter.
`default_nettype none

package isort_pkg;

    // Batch capacity, one cell for each value (2 to 64).
    localparam int MAX_ELEMS = 64;
    localparam int VALUE_W   = 32;
    // Wide enough to hold MAX_ELEMS itself.
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                      insert;
        logic                      shift;
        logic signed [VALUE_W-1:0] value;
    } isort_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/isort_cell.sv
// One cell of the sorting chain: holds one value and trades it with its neighbours.
`default_nettype none

module isort_cell (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire isort_pkg::isort_ctrl_t              ctrl,
    input  wire logic                                prev_gt,
    input  wire logic                                prev_valid,
    input  wire logic signed [isort_pkg::VALUE_W-1:0] prev_value,
    input  wire logic                                next_valid,
    input  wire logic signed [isort_pkg::VALUE_W-1:0] next_value,
    output logic                                     gt,
    output logic                                     valid,
    output logic signed [isort_pkg::VALUE_W-1:0]     value
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [isort_pkg::VALUE_W-1:0] value_reg;
    logic signed [isort_pkg::VALUE_W-1:0] value_next;

    // An empty cell counts as greater, so the first greater cell marks the slot.
    assign gt    = !valid_reg || (value_reg > ctrl.value);
    assign valid = valid_reg;
    assign value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert) begin
            if (gt) begin
                // Take the neighbour's value if it moves up, else the new one.
                value_next = prev_gt ? prev_value : ctrl.value;
                valid_next = valid_reg | prev_valid;
            end
        end else if (ctrl.shift) begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> rtl/introsort_sorter.sv
// Top level of the batch sorter: chain of insertion cells, batch control and output register.
`default_nettype none

// Channel | beat carries                         | tdata / tuser / tlast
// s_      | one value of the batch               | tdata[31:0] value, tlast end of batch
// m_      | next value in ascending signed order | tdata[31:0] value, tlast final,
//         |                                      | tuser[0] batch overflowed
//
// Cycles: one input beat per cycle while collecting; each value is inserted into
// its sorted place in the same cycle it is accepted. After the beat carrying tlast
// the chain shifts out one value per cycle while the m_ side is not stalled; input
// is held off (s_tready low) during the drain. Reset clears the cell valid bits,
// the count, the overflow flag and the output valid bit at once, with no clearing
// pass. A stalled m_ side freezes the chain and holds the beat.

module introsort_sorter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] in_value
    input  wire logic        s_tlast,   // last_in
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] out_value
    output logic             m_tlast,   // last_out
    output logic             m_tuser    // [0] overflow
);

    localparam int N = isort_pkg::MAX_ELEMS;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    state_t                         state_reg;
    logic [isort_pkg::CNT_W-1:0]    count_reg;
    logic                           ovf_reg;
    logic                           m_valid_reg;
    logic [31:0]                    m_data_reg;
    logic                           m_last_reg;
    logic                           m_user_reg;

    isort_pkg::isort_ctrl_t         ctrl;
    logic                           s_accept;
    logic                           full;
    logic                           out_free;
    logic                           shift;

    logic                           cell_gt    [N];
    logic                           cell_valid [N];
    logic signed [isort_pkg::VALUE_W-1:0] cell_value [N];

    assign s_tready = (state_reg == ST_COLLECT);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == isort_pkg::CNT_W'(N));
    // Output register is free when empty or its beat leaves this cycle.
    assign out_free = !m_valid_reg || m_tready;
    assign shift    = (state_reg == ST_DRAIN) && out_free;

    assign ctrl.insert = s_accept && !full;
    assign ctrl.shift  = shift;
    assign ctrl.value  = $signed(s_tdata);

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic                                prev_gt;
            logic                                prev_valid;
            logic signed [isort_pkg::VALUE_W-1:0] prev_value;
            logic                                next_valid;
            logic signed [isort_pkg::VALUE_W-1:0] next_value;

            if (gi == 0) begin : g_head
                // Head cell: nothing shifts in from below, so it takes the new value.
                assign prev_gt    = 1'b0;
                assign prev_valid = 1'b1;
                assign prev_value = '0;
            end else begin : g_body
                assign prev_gt    = cell_gt[gi-1];
                assign prev_valid = cell_valid[gi-1];
                assign prev_value = cell_value[gi-1];
            end

            if (gi == N - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_value = '0;
            end else begin : g_inner
                assign next_valid = cell_valid[gi+1];
                assign next_value = cell_value[gi+1];
            end

            isort_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_gt    (prev_gt),
                .prev_valid (prev_valid),
                .prev_value (prev_value),
                .next_valid (next_valid),
                .next_value (next_value),
                .gt         (cell_gt[gi]),
                .valid      (cell_valid[gi]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    // Batch control and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && !shift) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_COLLECT: begin
                    if (s_accept) begin
                        if (full) begin
                            // Drop the value and flag the batch.
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + isort_pkg::CNT_W'(1);
                        end
                        if (s_tlast) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (shift) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= 32'(cell_value[0]);
                        m_last_reg  <= !cell_valid[1];
                        m_user_reg  <= ovf_reg;
                        if (!cell_valid[1]) begin
                            // Final value leaves the chain: clear for the next batch.
                            state_reg <= ST_COLLECT;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    logic [N-1:0] valid_vec;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid_vec[i] = cell_valid[i];
        end
    end

    // Occupied cells always form an unbroken run from the head.
    a_valid_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + (N + 1)'(1)))
        else $error("cell valid bits not contiguous");

    // While collecting, the count matches the occupied cells.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COLLECT) |-> (count_reg == isort_pkg::CNT_W'($countones(valid_vec))))
        else $error("element count out of step with chain");

    // A draining batch always has a value at the head.
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty chain");

    // Emitting the final value leaves an empty chain and a cleared count.
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift && !cell_valid[1]) |=> (state_reg == ST_COLLECT) && (count_reg == '0)
            && !ovf_reg && (valid_vec == '0))
        else $error("chain not cleared after final beat");
`endif

endmodule

`default_nettype wire
